// ----- src/binary_trie_max_xor_assert.svh -----
// Assertion macros for the binary trie maximum-xor block.
// Used by binary_trie_max_xor.sv; needs nothing else.
`ifndef BINARY_TRIE_MAX_XOR_ASSERT_SVH
`define BINARY_TRIE_MAX_XOR_ASSERT_SVH

// same-cycle implication under reset
`define BTMX_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define BTMX_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/btmx_pkg.sv -----
// Shared types and codes for the binary trie maximum-xor block.
// No dependencies.
package btmx_pkg;

	localparam int KEY_W = 32;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_FULL = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_WALK  = 3'b010,
		S_ALLOC = 3'b100
	} state_t;

endpackage

// ----- src/binary_trie_max_xor.sv -----
// Binary trie maximum-xor block: top level with the walk sequencer.
// Depends on btmx_pkg, btmx_node_ram and binary_trie_max_xor_assert.svh.
//
// Usage:
//   A transaction is accepted on a rising edge with start high and busy low.
//   op selects insert (0) or query (1); key carries the key, of which only
//   the low KEY_BITS bits are used.
//   Every transaction gives one result: done is high for exactly one cycle
//   with max_xor, found and status valid. The receiver cannot stall; a
//   result not taken in that cycle is lost.
//   While walking, the node memory is read one node per cycle, one trie
//   level a cycle; a query ends at the leaf level, or at the root on an
//   empty trie. An insert that meets a missing link stops reading and
//   allocates the remaining nodes one by one before done.
//   An insert rejected for lack of KEY_BITS free nodes shows done in the
//   next cycle. busy is high while a walk or node allocation is in
//   progress; the next transaction may be accepted in the cycle its
//   predecessor shows done. Only one transaction is in progress at a time.
//   Reset empties the trie at once (root valid flag cleared, allocation
//   counter to one); there is no clearing pass.
module binary_trie_max_xor #(
	parameter int KEY_BITS  = 32,
	parameter int MAX_NODES = 65536
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   op,
	input  logic [btmx_pkg::KEY_W-1:0] key,
	output logic                   done,
	output logic [btmx_pkg::KEY_W-1:0] max_xor,
	output logic                   found,
	output logic                   status
);

	import btmx_pkg::*;

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int CNT_W  = NODE_W + 1;
	localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
	localparam int FREE_LIM = MAX_NODES - KEY_BITS;

	state_t               state_q;
	logic                 op_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [KEY_BITS-1:0]  best_q;
	logic [LVL_W-1:0]     lvl_q;
	logic                 leaf_q;
	logic [NODE_W-1:0]    node_q;
	logic [CNT_W-1:0]     next_free_q;
	logic                 done_q;
	logic [KEY_W-1:0]     max_xor_q;
	logic                 found_q;
	logic                 status_q;

	logic                 accept;
	logic                 is_full;
	logic [NODE_W-1:0]    new_id;
	logic                 cur_bit;
	logic                 last_lvl;
	logic [NODE_W-1:0]    lk0, lk1, lk_same, lk_opp;
	logic [NODE_W-1:0]    nxt;
	logic                 took;
	logic                 miss;
	logic [KEY_BITS-1:0]  best_nx;
	logic [2*NODE_W-1:0]  rd_data;
	logic                 rd_en, wr_en;
	logic [NODE_W-1:0]    rd_addr, wr_addr;
	logic [2*NODE_W-1:0]  wr_data;

	btmx_node_ram #(
		.DEPTH  (MAX_NODES),
		.NODE_W (NODE_W)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign is_full  = (next_free_q > CNT_W'(FREE_LIM));
	assign new_id   = next_free_q[NODE_W-1:0];
	assign cur_bit  = key_q[lvl_q];
	assign last_lvl = (lvl_q == '0);
	assign lk0      = rd_data[NODE_W-1:0];
	assign lk1      = rd_data[2*NODE_W-1:NODE_W];
	assign lk_same  = cur_bit ? lk1 : lk0;
	assign lk_opp   = cur_bit ? lk0 : lk1;

	always_comb begin
		if (op_q == OP_QUERY) begin
			if (lk_opp != '0) begin
				took = ~cur_bit;
				nxt  = lk_opp;
			end else begin
				took = cur_bit;
				nxt  = lk_same;
			end
		end else begin
			took = cur_bit;
			nxt  = lk_same;
		end
		miss    = (nxt == '0);
		best_nx = best_q | (KEY_BITS'(took) << lvl_q);
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = node_q;
		wr_data = '0;
		unique case (state_q)
			S_IDLE: begin
				rd_en = accept;
			end
			S_WALK: begin
				rd_en   = !miss && !last_lvl;
				rd_addr = nxt;
				if (op_q == OP_INSERT && miss) begin
					wr_en   = 1'b1;
					wr_data = cur_bit ? {new_id, lk0} : {lk1, new_id};
				end
			end
			S_ALLOC: begin
				wr_en = 1'b1;
				if (!leaf_q) begin
					wr_data = cur_bit ? {new_id, {NODE_W{1'b0}}} : {{NODE_W{1'b0}}, new_id};
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_INSERT;
			key_q       <= '0;
			best_q      <= '0;
			lvl_q       <= '0;
			leaf_q      <= 1'b0;
			node_q      <= '0;
			next_free_q <= CNT_W'(1);
			done_q      <= 1'b0;
			max_xor_q   <= '0;
			found_q     <= 1'b0;
			status_q    <= STAT_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q   <= op;
						key_q  <= key[KEY_BITS-1:0];
						best_q <= '0;
						lvl_q  <= LVL_W'(KEY_BITS - 1);
						leaf_q <= 1'b0;
						node_q <= '0;
						if (op == OP_INSERT && is_full) begin
							done_q    <= 1'b1;
							max_xor_q <= '0;
							found_q   <= 1'b0;
							status_q  <= STAT_FULL;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (op_q == OP_QUERY) begin
						best_q <= best_nx;
						if (miss) begin
							done_q    <= 1'b1;
							max_xor_q <= '0;
							found_q   <= 1'b0;
							status_q  <= STAT_OK;
							state_q   <= S_IDLE;
						end else if (last_lvl) begin
							done_q    <= 1'b1;
							max_xor_q <= KEY_W'(key_q ^ best_nx);
							found_q   <= 1'b1;
							status_q  <= STAT_OK;
							state_q   <= S_IDLE;
						end else begin
							lvl_q  <= lvl_q - 1'b1;
							node_q <= nxt;
						end
					end else if (miss) begin
						next_free_q <= next_free_q + 1'b1;
						node_q      <= new_id;
						state_q     <= S_ALLOC;
						if (last_lvl) begin
							leaf_q <= 1'b1;
						end else begin
							lvl_q <= lvl_q - 1'b1;
						end
					end else if (last_lvl) begin
						done_q    <= 1'b1;
						max_xor_q <= '0;
						found_q   <= 1'b0;
						status_q  <= STAT_OK;
						state_q   <= S_IDLE;
					end else begin
						lvl_q  <= lvl_q - 1'b1;
						node_q <= nxt;
					end
				end
				S_ALLOC: begin
					if (leaf_q) begin
						done_q    <= 1'b1;
						max_xor_q <= '0;
						found_q   <= 1'b0;
						status_q  <= STAT_OK;
						state_q   <= S_IDLE;
					end else begin
						next_free_q <= next_free_q + 1'b1;
						node_q      <= new_id;
						if (last_lvl) begin
							leaf_q <= 1'b1;
						end else begin
							lvl_q <= lvl_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done    = done_q;
	assign max_xor = max_xor_q;
	assign found   = found_q;
	assign status  = status_q;

	`include "binary_trie_max_xor_assert.svh"

	`BTMX_ASSERT_NOW(a_res_excl, clk, arst_n, done_q, !(found_q && status_q == STAT_FULL), "found and full together")
	`BTMX_ASSERT_NEXT(a_acc_prog, clk, arst_n, accept, busy || done_q, "accepted transaction dropped")
	`BTMX_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, next_free_q <= CNT_W'(MAX_NODES), "node counter overrun")
	`BTMX_ASSERT_NOW(a_alloc_ins, clk, arst_n, state_q == S_ALLOC, op_q == OP_INSERT, "allocation outside insert")
	`BTMX_ASSERT_NOW(a_wr_busy, clk, arst_n, wr_en, busy && op_q == OP_INSERT, "node write outside insert walk")

endmodule

// ----- src/btmx_node_ram.sv -----
// Trie node memory: two child links per node, one write and one read port,
// registered read data. Root entry reads as null until first written.
module btmx_node_ram #(
	parameter int DEPTH  = 65536,
	parameter int NODE_W = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [NODE_W-1:0]     rd_addr,
	output logic [2*NODE_W-1:0]   rd_data,
	input  logic                  wr_en,
	input  logic [NODE_W-1:0]     wr_addr,
	input  logic [2*NODE_W-1:0]   wr_data
);

	logic [2*NODE_W-1:0] mem [DEPTH];
	logic [2*NODE_W-1:0] rd_data_s1;
	logic                rd_root_s1;
	logic                root_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_vld_q <= 1'b0;
			rd_root_s1 <= 1'b0;
		end else begin
			if (wr_en && (wr_addr == '0)) begin
				root_vld_q <= 1'b1;
			end
			if (rd_en) begin
				rd_root_s1 <= (rd_addr == '0);
			end
		end
	end

	assign rd_data = (rd_root_s1 && !root_vld_q) ? '0 : rd_data_s1;

endmodule
